### hw/rtl/sog_pkg.sv
// types, constants and the quarter-wave table of the sine oscillator
`timescale 1ns / 1ps
`default_nettype none

package sog_pkg;

    localparam int TABLE_BITS  = 10;
    localparam int SAMPLE_RATE = 44100;

    localparam int FREQ_IN_W = 16;
    localparam int FREQ_W    = 15;
    localparam int SAMPLE_W  = 16;
    localparam int PHASE_W   = 32;
    localparam int AMP_W     = 15;

    localparam logic [FREQ_W-1:0] MAX_FREQ_RST = 15'd2000;

    // quarter-wave table geometry
    localparam int QUARTER = 1 << (TABLE_BITS - 2);
    localparam int POS_W   = TABLE_BITS - 2;
    localparam int TIDX_W  = TABLE_BITS - 1;

    localparam logic [63:0] AMP         = 64'd32767;
    localparam logic [63:0] HALF_PI_Q28 = 64'd421657428;

    // target increment: f * 2^32 / SAMPLE_RATE split as f*INC_A + (f*INC_B + half) / rate
    localparam int          SR_W    = $clog2(SAMPLE_RATE + 1);
    localparam int          HALF_SR = SAMPLE_RATE / 2;
    localparam logic [63:0] TWO32   = 64'h1_0000_0000;
    localparam logic [63:0] INC_A   = TWO32 / SAMPLE_RATE;
    localparam logic [63:0] INC_B   = TWO32 % SAMPLE_RATE;
    localparam int          Y_W     = FREQ_W + SR_W;
    localparam int          M_W     = FREQ_W + 2;
    localparam logic [63:0] RECIP   = (64'd1 << Y_W) / SAMPLE_RATE;

    // glide coefficients, 0.95 and 0.05 in Q16
    localparam int          COEF_W    = 16;
    localparam logic [63:0] COEF_KEEP = 64'd62259;
    localparam logic [63:0] COEF_NEW  = 64'd3277;
    localparam logic [63:0] ROUND     = 64'd32768;

    // shared multiplier operand widths
    localparam int MA_W  = (Y_W > PHASE_W) ? Y_W : PHASE_W;
    localparam int MB_T  = (SR_W > M_W) ? SR_W : M_W;
    localparam int MB_W  = (MB_T > COEF_W) ? MB_T : COEF_W;
    localparam int P_W   = MA_W + MB_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              start;
        logic [FREQ_W-1:0] freq;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_B,
        S_RECIP,
        S_REM,
        S_TINC,
        S_KEEP,
        S_NEW,
        S_ACC,
        S_LOOK
    } t_state;

    typedef logic [AMP_W-1:0] t_qtab [0:QUARTER];

    // sin(x) in Q28 by the alternating series through x^11
    function automatic logic [63:0] sine_q28(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = (x * x) >> 28;
        term = x;
        sum  = x;
        term = ((term * x2) >> 28) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 28) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 28) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 28) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 28) / 64'd110;
        sum  = sum - term;
        return {32'd0, sum[31:0]};
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab       tab;
        logic [63:0] x;
        logic [63:0] v;
        for (int k = 0; k <= QUARTER; k++) begin
            x = (64'(k) * HALF_PI_Q28 + 64'(QUARTER / 2)) / QUARTER;
            v = (sine_q28(x) * AMP + (64'd1 << 27)) >> 28;
            if (v > AMP) begin
                v = AMP;
            end
            tab[k] = v[AMP_W-1:0];
        end
        return tab;
    endfunction

    localparam t_qtab QTAB = build_qtab();

endpackage

`default_nettype wire

### hw/rtl/sog_ifs.sv
// valid/ready channel interfaces for the oscillator input and sample output
`timescale 1ns / 1ps
`default_nettype none

interface sog_in_if;
    import sog_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [FREQ_IN_W-1:0] target_freq;
    logic                 block_start;

    modport source (output valid, output target_freq, output block_start, input ready);
    modport sink (input valid, input target_freq, input block_start, output ready);
endinterface

interface sog_out_if;
    import sog_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

`default_nettype wire

### hw/rtl/sog_front.sv
// front end: input transfer, max frequency register and clamp, command stage
`timescale 1ns / 1ps
`default_nettype none

module sog_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [sog_pkg::FREQ_W-1:0]    i_cfg_wdata,
    sog_in_if.sink                       i_in,
    output sog_pkg::t_cmd                o_cmd,
    output logic                         o_cmd_valid,
    input  wire                          i_cmd_ready
);
    import sog_pkg::*;

    logic [FREQ_W-1:0] r_max_freq;
    logic              r_cmd_valid;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic              w_accept;

    assign i_in.ready = !r_cmd_valid || i_cmd_ready;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_cmd.start = i_in.block_start;
        if (i_in.target_freq > FREQ_IN_W'(r_max_freq)) begin
            n_cmd.freq = r_max_freq;
        end else begin
            n_cmd.freq = i_in.target_freq[FREQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_freq  <= MAX_FREQ_RST;
            r_cmd_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_freq <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_cmd_valid <= 1'b1;
            end else if (i_cmd_ready) begin
                r_cmd_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd       = r_cmd;
    assign o_cmd_valid = r_cmd_valid;

endmodule

`default_nettype wire

### hw/rtl/sog_queue.sv
// short command queue between front and back end
`timescale 1ns / 1ps
`default_nettype none

module sog_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push_valid,
    output logic            o_push_ready,
    input  sog_pkg::t_cmd   i_push_data,
    output logic            o_pop_valid,
    input  wire             i_pop_ready,
    output sog_pkg::t_cmd   o_pop_data
);
    import sog_pkg::*;

    t_cmd               r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = (r_count != Q_CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sog_back.sv
// back end: glide sequencer on a shared multiplier, phase accumulator, sine lookup
`timescale 1ns / 1ps
`default_nettype none

module sog_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  sog_pkg::t_cmd   i_cmd,
    input  wire             i_cmd_valid,
    output logic            o_cmd_ready,
    sog_out_if.source       o_out
);
    import sog_pkg::*;

    t_state                     r_state;
    t_state                     n_state;

    logic [FREQ_W-1:0]          r_f;
    logic [Y_W-1:0]             r_y;
    logic [FREQ_W-1:0]          r_q;
    logic [SR_W:0]              r_rem;
    logic [PHASE_W-1:0]         r_tinc;
    logic [P_W-1:0]             r_keep;
    logic [PHASE_W-1:0]         r_step;
    logic [PHASE_W-1:0]         r_phase;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_sample;

    logic [MA_W-1:0]            w_mul_a;
    logic [MB_W-1:0]            w_mul_b;
    logic [P_W-1:0]             w_prod;
    logic                       w_pop;
    logic                       w_out_free;
    logic                       w_load_out;
    logic                       w_fix;
    logic                       w_f_sat;
    logic [PHASE_W:0]           w_tinc_wide;
    logic [PHASE_W-1:0]         w_tinc_next;
    logic [P_W-1:0]             w_glide_sum;
    logic [PHASE_W-1:0]         w_step_next;
    logic [1:0]                 w_quad;
    logic [POS_W-1:0]           w_pos;
    logic [TIDX_W-1:0]          w_tidx;
    logic [AMP_W-1:0]           w_mag;
    logic signed [SAMPLE_W-1:0] w_mag_s;
    logic signed [SAMPLE_W-1:0] w_sample;

    // one multiplier, operands chosen by the sequencer step
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_MUL_B: begin
                w_mul_a = MA_W'(r_f);
                w_mul_b = MB_W'(INC_B);
            end
            S_RECIP: begin
                w_mul_a = MA_W'(r_y);
                w_mul_b = MB_W'(RECIP);
            end
            S_REM: begin
                w_mul_a = MA_W'(SAMPLE_RATE);
                w_mul_b = MB_W'(r_q);
            end
            S_TINC: begin
                w_mul_a = MA_W'(INC_A);
                w_mul_b = MB_W'(r_f);
            end
            S_KEEP: begin
                w_mul_a = MA_W'(r_step);
                w_mul_b = MB_W'(COEF_KEEP);
            end
            S_NEW: begin
                w_mul_a = MA_W'(r_tinc);
                w_mul_b = MB_W'(COEF_NEW);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = P_W'(w_mul_a) * P_W'(w_mul_b);

    // reciprocal quotient is low by at most one, the remainder fixes it
    assign w_fix       = (r_rem >= (SR_W + 1)'(SAMPLE_RATE));
    assign w_f_sat     = (32'(r_f) >= 32'(SAMPLE_RATE));
    assign w_tinc_wide = (PHASE_W + 1)'(w_prod) + (PHASE_W + 1)'(r_q)
                       + (PHASE_W + 1)'(w_fix);
    assign w_tinc_next = (w_f_sat || w_tinc_wide[PHASE_W]) ? '1
                       : w_tinc_wide[PHASE_W-1:0];

    assign w_glide_sum = r_keep + w_prod;
    assign w_step_next = (w_glide_sum[P_W-1:COEF_W+PHASE_W] != '0) ? '1
                       : w_glide_sum[COEF_W +: PHASE_W];

    // quadrant folding of the quarter-wave table
    assign w_quad   = r_phase[PHASE_W-1 -: 2];
    assign w_pos    = r_phase[PHASE_W-3 -: POS_W];
    assign w_tidx   = w_quad[0] ? (TIDX_W'(QUARTER) - TIDX_W'(w_pos)) : TIDX_W'(w_pos);
    assign w_mag    = QTAB[w_tidx];
    assign w_mag_s  = signed'({1'b0, w_mag});
    assign w_sample = w_quad[1] ? -w_mag_s : w_mag_s;

    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state     = r_state;
        o_cmd_ready = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_state = i_cmd.start ? S_MUL_B : S_LOOK;
                end
            end
            S_MUL_B: n_state = S_RECIP;
            S_RECIP: n_state = S_REM;
            S_REM:   n_state = S_TINC;
            S_TINC:  n_state = S_KEEP;
            S_KEEP:  n_state = S_NEW;
            S_NEW:   n_state = S_ACC;
            S_ACC:   n_state = S_LOOK;
            S_LOOK: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_pop = o_cmd_ready && i_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop && !i_cmd.start) begin
                r_phase <= r_phase + r_step;
            end
            if (r_state == S_NEW) begin
                r_step <= w_step_next;
            end
            if (r_state == S_ACC) begin
                r_phase <= r_phase + r_step;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_f <= i_cmd.freq;
        end
        if (r_state == S_MUL_B) begin
            r_y <= Y_W'(w_prod) + Y_W'(HALF_SR);
        end
        if (r_state == S_RECIP) begin
            r_q <= FREQ_W'(w_prod >> Y_W);
        end
        if (r_state == S_REM) begin
            r_rem <= (SR_W + 1)'(r_y - Y_W'(w_prod));
        end
        if (r_state == S_TINC) begin
            r_tinc <= w_tinc_next;
        end
        if (r_state == S_KEEP) begin
            r_keep <= w_prod + P_W'(ROUND);
        end
        if (w_load_out) begin
            r_sample <= w_sample;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.left_sample  = r_sample;
    assign o_out.right_sample = r_sample;

endmodule

`default_nettype wire

### hw/rtl/sine_oscillator_with_glide_top.sv
// top level of the sine oscillator with frequency glide
// path: an input transfer goes through the command stage and the queue to the back end, which
// takes one sample at a time and holds it while the output is not taken; a block_start sample
//   also runs the glide update as seven steps on its one shared multiplier
// reset: phase and phase step go to zero, max_freq to 2000, queue and output empty;
//   the sine table is constant and needs no fill after reset
`timescale 1ns / 1ps
`default_nettype none

module sine_oscillator_with_glide_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [sog_pkg::FREQ_W-1:0]    i_cfg_wdata,
    sog_in_if.sink                       i_in,
    sog_out_if.source                    o_out
);
    import sog_pkg::*;

    t_cmd w_push_data;
    logic w_push_valid;
    logic w_push_ready;
    t_cmd w_pop_data;
    logic w_pop_valid;
    logic w_pop_ready;

    sog_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .o_cmd       (w_push_data),
        .o_cmd_valid (w_push_valid),
        .i_cmd_ready (w_push_ready)
    );

    sog_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    sog_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_pop_data),
        .i_cmd_valid (w_pop_valid),
        .o_cmd_ready (w_pop_ready),
        .o_out       (o_out)
    );

    // an accepted item sits in the command stage on the next cycle
    a_front_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> w_push_valid)
        else $error("accepted item missing from command stage");

    // back end never takes two commands in a row
    a_back_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop_valid && w_pop_ready) |=> !w_pop_ready)
        else $error("back end popped on consecutive cycles");

    // folded table output stays symmetric
    a_no_min_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.left_sample != 16'sh8000))
        else $error("sample outside symmetric range");

endmodule

`default_nettype wire

### verif/testbench.sv
// self-checking testbench for the sine oscillator with frequency glide
`timescale 1ns / 1ps

module testbench;
    import sog_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;
    localparam int IDLE_MAX     = 4;

    localparam longint unsigned GLIDE_KEEP     = 62259;
    localparam longint unsigned GLIDE_NEW      = 3277;
    localparam longint unsigned GLIDE_ROUND    = 32768;
    localparam longint unsigned STEP_MAX       = 64'hFFFF_FFFF;
    localparam longint unsigned QUARTER_PI_Q28 = 421657428;
    localparam longint unsigned FULL_SCALE     = 32767;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [FREQ_W-1:0] cfg_wdata;

    sog_in_if  tone_in ();
    sog_out_if tone_out ();

    sine_oscillator_with_glide_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (tone_in),
        .o_out       (tone_out)
    );

    // oscillator state as the design should hold it
    int unsigned                quarter_sine [0:QUARTER];
    logic [PHASE_W-1:0]         osc_phase;
    logic [PHASE_W-1:0]         osc_step;
    logic [FREQ_W-1:0]          clamp_hz;
    logic signed [SAMPLE_W-1:0] pending_samples [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    bit src_idle_en;
    bit snk_idle_en;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // quarter-wave table from the truncated taylor series in q28
    initial begin : build_sine_table
        longint unsigned ang;
        longint unsigned sq;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned mag;
        for (int k = 0; k <= QUARTER; k++) begin
            ang  = (longint'(k) * QUARTER_PI_Q28 + QUARTER / 2) / QUARTER;
            sq   = (ang * ang) >> 28;
            term = ang;
            acc  = ang;
            for (int n = 1; n <= 5; n++) begin
                term = ((term * sq) >> 28) / longint'((2 * n) * (2 * n + 1));
                acc  = (n % 2) ? acc - term : acc + term;
            end
            acc = acc & 64'hFFFF_FFFF;
            mag = (acc * FULL_SCALE + (64'd1 << 27)) >> 28;
            quarter_sine[k] = 32'((mag > FULL_SCALE) ? FULL_SCALE : mag);
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] next_sine_sample(
        input logic [FREQ_IN_W-1:0] freq,
        input logic                 start
    );
        longint unsigned            hz;
        longint unsigned            target_inc;
        longint unsigned            glided;
        logic [TABLE_BITS-1:0]      idx;
        logic [1:0]                 quad;
        logic [POS_W-1:0]           pos;
        int unsigned                mag;
        logic signed [SAMPLE_W-1:0] sample;
        if (start) begin
            hz = 64'((freq > FREQ_IN_W'(clamp_hz)) ? FREQ_IN_W'(clamp_hz) : freq);
            target_inc = ((hz << 32) + SAMPLE_RATE / 2) / SAMPLE_RATE;
            if (target_inc > STEP_MAX) begin
                target_inc = STEP_MAX;
            end
            glided = (GLIDE_KEEP * 64'(osc_step) + GLIDE_NEW * target_inc + GLIDE_ROUND) >> 16;
            if (glided > STEP_MAX) begin
                glided = STEP_MAX;
            end
            osc_step = glided[31:0];
        end
        osc_phase = osc_phase + osc_step;
        idx  = osc_phase[PHASE_W-1 -: TABLE_BITS];
        quad = idx[TABLE_BITS-1 -: 2];
        pos  = idx[POS_W-1:0];
        // odd quadrants run the table backward, the upper half is negated
        mag = quad[0] ? quarter_sine[QUARTER - pos] : quarter_sine[pos];
        sample = mag[SAMPLE_W-1:0];
        if (quad[1]) begin
            sample = -sample;
        end
        return sample;
    endfunction

    task automatic send_request(input logic [FREQ_IN_W-1:0] freq, input logic start);
        int gap;
        gap = src_idle_en ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            tone_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tone_in.valid       <= 1'b1;
        tone_in.target_freq <= freq;
        tone_in.block_start <= start;
        do @(posedge i_clk); while (!tone_in.ready);
        pending_samples.push_back(next_sine_sample(freq, start));
    endtask

    task automatic wait_for_samples();
        tone_in.valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_max_freq(input logic [FREQ_W-1:0] hz);
        wait_for_samples();
        cfg_we    <= 1'b1;
        cfg_wdata <= hz;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        clamp_hz = hz;
    endtask

    // reset clamp of 2000 hz, including targets far above it
    task automatic test_default_clamp();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        send_request(16'd0, 1'b1);
        send_request(16'hFFFF, 1'b1);
        send_request(16'd2000, 1'b1);
        send_request(16'd2001, 1'b1);
        send_request(16'd1999, 1'b1);
        send_request(16'h8000, 1'b1);
    endtask

    // without a block start the target is ignored and the step holds
    task automatic test_hold_without_start();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        send_request(16'hFFFF, 1'b0);
        send_request(16'd0, 1'b0);
        send_request(16'd12345, 1'b0);
        send_request(16'd1000, 1'b1);
        send_request(16'd40000, 1'b0);
    endtask

    // clamp at zero, at the top of the register and at nyquist
    task automatic test_clamp_settings();
        set_max_freq(15'd0);
        send_request(16'hFFFF, 1'b1);
        send_request(16'd1, 1'b1);
        send_request(16'd0, 1'b0);
        set_max_freq(15'h7FFF);
        send_request(16'hFFFF, 1'b1);
        send_request(16'd32767, 1'b1);
        send_request(16'd32768, 1'b1);
        send_request(16'd22051, 1'b1);
        set_max_freq(15'd22050);
        send_request(16'd22050, 1'b1);
        send_request(16'd22051, 1'b1);
        send_request(16'hFFFF, 1'b1);
        send_request(16'd0, 1'b0);
    endtask

    // buffer blocks: a start sample with a held tone, then free-running samples; some blocks have random start flags
    task automatic test_random_blocks();
        int                   sent;
        int                   len;
        int                   kind;
        int                   max_len;
        logic [FREQ_IN_W-1:0] tone_hz;
        logic [FREQ_IN_W-1:0] freq;
        logic                 start;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    set_max_freq(15'($urandom_range(100, 22050)));
                end
                1: begin
                    set_max_freq(15'd22050);
                end
                2: begin
                    set_max_freq(15'h7FFF);
                end
                default: begin
                    set_max_freq(15'($urandom_range(0, 32767)));
                end
            endcase
            max_len     = (ph == 0) ? 4 : 16;
            src_idle_en = (ph % 2 == 0) ? 1'b1 : 1'($urandom_range(0, 1));
            snk_idle_en = (ph % 2 == 0) ? 1'b1 : 1'($urandom_range(0, 1));
            tone_hz     = 16'($urandom_range(0, clamp_hz));
            sent        = 0;
            while (sent < 190) begin
                len  = $urandom_range(1, max_len);
                kind = $urandom_range(0, 9);
                if ($urandom_range(0, 5) == 0) begin
                    tone_hz = (kind < 7) ? 16'($urandom_range(0, clamp_hz)) : 16'($urandom);
                end
                for (int j = 0; j < len; j++) begin
                    if (kind == 0) begin
                        // broken block: start flags at random
                        freq  = 16'($urandom);
                        start = 1'($urandom_range(0, 1));
                    end else if (j == 0) begin
                        freq  = tone_hz;
                        start = 1'b1;
                    end else begin
                        freq  = 16'($urandom);
                        start = 1'b0;
                    end
                    send_request(freq, start);
                    sent++;
                end
                if ($urandom_range(0, 15) == 0) begin
                    src_idle_en = ~src_idle_en;
                end
                if ($urandom_range(0, 15) == 0) begin
                    snk_idle_en = ~snk_idle_en;
                end
            end
        end
    endtask

    // sender stops until every sample is out, then resumes
    task automatic test_drain_pause();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 8; j++) begin
                send_request(16'($urandom), (j % 4) == 0);
            end
            wait_for_samples();
        end
    endtask

    initial begin : sample_checker
        int                         gap;
        logic signed [SAMPLE_W-1:0] want;
        tone_out.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            gap = snk_idle_en ? $urandom_range(0, IDLE_MAX) : 0;
            if (gap > 0) begin
                tone_out.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            tone_out.ready <= 1'b1;
            do @(posedge i_clk); while (tone_out.valid !== 1'b1);
            if (pending_samples.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected sample transfer: left %0d right %0d",
                             tone_out.left_sample, tone_out.right_sample);
                end
            end else begin
                want = pending_samples.pop_front();
                if (tone_out.left_sample !== want || tone_out.right_sample !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("sample error: expected %0d, got left %0d right %0d",
                                 want, tone_out.left_sample, tone_out.right_sample);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin : run_tests
        tone_in.valid       = 1'b0;
        tone_in.target_freq = '0;
        tone_in.block_start = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        i_rst_n             = 1'b0;
        src_idle_en         = 1'b0;
        snk_idle_en         = 1'b0;
        osc_phase           = '0;
        osc_step            = '0;
        clamp_hz            = MAX_FREQ_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_clamp();
        test_hold_without_start();
        test_clamp_settings();
        test_random_blocks();
        test_drain_pause();
        wait_for_samples();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
